// File: design/assert_macros.svh
// Assertion macros for the tangent-space builder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a condition holds at every rising clock edge outside reset
`define TTSB_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// Check that a condition holds in the cycle after a trigger
`define TTSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TTSB_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define TTSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: design/ttsb_pkg.sv
// Shared types and constants of the tangent-space builder.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package ttsb_pkg;

    // Command codes on the input tuser
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 256;
    localparam int IDX_W     = 10;
    localparam int CRD_W     = 32;
    localparam int UNIT_W    = 16;
    localparam int GEOM_W    = 5 * CRD_W;
    localparam int FRAME_W   = 6 * UNIT_W;
    localparam int CNT_W     = 5;

    localparam logic [UNIT_W-1:0] ONE_Q14 = 16'd16384;

    // Last step of each iterated phase
    localparam logic [CNT_W-1:0] FETCH_TRI_LAST  = 5'd3;
    localparam logic [CNT_W-1:0] FETCH_READ_LAST = 5'd1;
    localparam logic [CNT_W-1:0] MUL_LAST        = 5'd14;
    localparam logic [CNT_W-1:0] SQ_LAST         = 5'd3;
    localparam logic [CNT_W-1:0] SQRT_LAST       = 5'd31;
    localparam logic [CNT_W-1:0] DIV_LAST        = 5'd14;
    localparam logic [CNT_W-1:0] WRITE_LAST      = 5'd2;
    localparam logic [1:0]       COMP_LAST       = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_FETCH,
        OP_EDGE,
        OP_FIT,
        OP_MUL,
        OP_SIGN,
        OP_NLOAD,
        OP_NSHIFT,
        OP_SQ,
        OP_SQRT,
        OP_DLOAD,
        OP_DSTEP,
        OP_DSTORE,
        OP_WRITE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] cnt;
        logic             vsel;
        logic [1:0]       comp;
        status_t          stat;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_bad;
        logic       full;
        logic       det_zero;
        logic       m_zero;
        logic       m_ok;
        logic       out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: design/ttsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the vertex stores of the datapath.
`default_nettype none

module ttsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/ttsb_ctrl.sv
// Sequencing controller of the tangent-space builder.
// Depends on ttsb_pkg; drives the datapath by command and reads its status.
`default_nettype none

module ttsb_ctrl
    import ttsb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DISP   = 16'h0002,
        S_FETCH  = 16'h0004,
        S_EDGE   = 16'h0008,
        S_FIT    = 16'h0010,
        S_MUL    = 16'h0020,
        S_SIGN   = 16'h0040,
        S_NLOAD  = 16'h0080,
        S_NSHIFT = 16'h0100,
        S_SQ     = 16'h0200,
        S_SQRT   = 16'h0400,
        S_DLOAD  = 16'h0800,
        S_DSTEP  = 16'h1000,
        S_DSTORE = 16'h2000,
        S_WRITE  = 16'h4000,
        S_FINISH = 16'h8000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             vsel_reg, vsel_next;
    logic [1:0]       comp_reg, comp_next;
    status_t          stat_reg, stat_next;
    logic [CNT_W-1:0] fetch_last;

    assign fetch_last = (sts.cmd == CMD_TRI) ? FETCH_TRI_LAST : FETCH_READ_LAST;
    assign s_tready   = (state_reg == S_IDLE);

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vsel_next  = vsel_reg;
        comp_next  = comp_reg;
        stat_next  = stat_reg;
        cmd.op     = OP_NONE;
        cmd.cnt    = cnt_reg;
        cmd.vsel   = vsel_reg;
        cmd.comp   = comp_reg;
        cmd.stat   = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cnt_next  = '0;
                vsel_next = 1'b0;
                comp_next = '0;
                stat_next = ST_OK;
                case (sts.cmd)
                    CMD_ADD:
                    begin
                        if (sts.full)
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op = OP_ADD;
                        end
                        state_next = S_FINISH;
                    end
                    CMD_TRI, CMD_READ:
                    begin
                        if (sts.idx_bad)
                        begin
                            stat_next  = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.op = OP_FETCH;
                if (cnt_reg == fetch_last)
                begin
                    state_next = (sts.cmd == CMD_TRI) ? S_EDGE : S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EDGE:
            begin
                cmd.op     = OP_EDGE;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SIGN:
            begin
                cmd.op = OP_SIGN;
                if (sts.det_zero)
                begin
                    stat_next  = ST_DEGEN;
                    state_next = S_FINISH;
                end
                else
                begin
                    vsel_next  = 1'b0;
                    state_next = S_NLOAD;
                end
            end
            S_NLOAD:
            begin
                cmd.op     = OP_NLOAD;
                comp_next  = '0;
                state_next = S_NSHIFT;
            end
            S_NSHIFT:
            begin
                if (sts.m_zero)
                begin
                    stat_next  = ST_DEGEN;
                    state_next = S_FINISH;
                end
                else if (sts.m_ok)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.op = OP_NSHIFT;
                end
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DLOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DLOAD:
            begin
                cmd.op     = OP_DLOAD;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op = OP_DSTEP;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DSTORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DSTORE:
            begin
                cmd.op = OP_DSTORE;
                if (comp_reg != COMP_LAST)
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = S_DLOAD;
                end
                else if (!vsel_reg)
                begin
                    vsel_next  = 1'b1;
                    state_next = S_NLOAD;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.op = OP_WRITE;
                if (cnt_reg == WRITE_LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            vsel_reg  <= 1'b0;
            comp_reg  <= '0;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vsel_reg  <= vsel_next;
            comp_reg  <= comp_next;
            stat_reg  <= stat_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ttsb_dpath.sv
// Datapath of the tangent-space builder: vertex stores, shared multiplier,
// bit-serial square root and divider, output register. Depends on ttsb_pkg, ttsb_ram.
`default_nettype none

module ttsb_dpath
    import ttsb_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_cmd_t             cmd,
    output dp_sts_t                   sts,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                m_tuser
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Captured item
    logic [1:0]        cmd_reg;
    logic [GEOM_W-1:0] geom_in_reg;
    logic [IDX_W-1:0]  ia_reg, ib_reg, ic_reg;

    logic [CW-1:0]     count_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    // Working registers
    logic [GEOM_W-1:0]        vtx_reg [3];
    logic [FRAME_W-1:0]       frame_reg;
    logic signed [32:0]       ediff_reg [6];
    logic signed [32:0]       ddiff_reg [4];
    logic signed [30:0]       e_reg [6];
    logic signed [30:0]       d_reg [4];
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       res_reg [7];
    logic [61:0]              m_reg [3];
    logic [2:0]               neg_reg;
    logic [63:0]              n_reg, r_reg, bit_reg;
    logic [31:0]              rem_reg;
    logic [14:0]              dnum_reg;
    logic [14:0]              q_reg;
    logic [UNIT_W-1:0]        tu_reg [3];
    logic [UNIT_W-1:0]        bu_reg [3];

    // Memory ports
    logic              geom_we, frame_we, rd_en;
    logic [AW-1:0]     waddr, raddr;
    logic [GEOM_W-1:0] geom_rdata;
    logic [FRAME_W-1:0] frame_wdata, frame_rdata;

    logic [IDX_W-1:0]  idx_sel;
    logic [16:0]       idx_ext, cnt_ext;
    logic [16:0]       ia_ext, ib_ext, ic_ext;
    logic [61:0]       mx;
    logic signed [31:0] mul_a, mul_b;
    logic [1:0]        ke, kd;
    logic [3:0]        mul_j;
    logic [1:0]        lat_idx;
    logic [44:0]       div_num;
    logic [31:0]       div_t;
    logic [31:0]       len;
    logic [63:0]       sq_try;
    logic [UNIT_W-1:0] q_ext;

    function automatic logic fits31(input logic signed [32:0] v);
        return (v[32:30] == 3'b000) || (v[32:30] == 3'b111);
    endfunction

    // Pick the vertex index for the current fetch or write step
    always_comb
    begin
        case (cmd.cnt[1:0])
            2'd0:    idx_sel = ia_reg;
            2'd1:    idx_sel = ib_reg;
            default: idx_sel = ic_reg;
        endcase
    end

    assign idx_ext = 17'(idx_sel);
    assign cnt_ext = 17'(count_reg);
    assign ia_ext  = 17'(ia_reg);
    assign ib_ext  = 17'(ib_reg);
    assign ic_ext  = 17'(ic_reg);

    // Status towards the controller
    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
    end

    assign sts.cmd      = cmd_reg;
    assign sts.idx_bad  = (ia_ext >= cnt_ext) ||
                          ((cmd_reg == CMD_TRI) && ((ib_ext >= cnt_ext) || (ic_ext >= cnt_ext)));
    assign sts.full     = (count_reg == CW'(MAX_VERTICES));
    assign sts.det_zero = (res_reg[0] == 64'sd0);
    assign sts.m_zero   = (mx == 62'd0);
    assign sts.m_ok     = (mx[61:30] == '0) && mx[29];
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    // Memory controls
    assign geom_we     = (cmd.op == OP_ADD);
    assign frame_we    = (cmd.op == OP_ADD) || (cmd.op == OP_WRITE);
    assign waddr       = (cmd.op == OP_ADD) ? count_reg[AW-1:0] : idx_ext[AW-1:0];
    assign rd_en       = (cmd.op == OP_FETCH) && (cmd.cnt < FETCH_TRI_LAST);
    assign raddr       = idx_ext[AW-1:0];
    assign frame_wdata = (cmd.op == OP_ADD) ?
                         {ONE_Q14, 16'd0, 16'd0, ONE_Q14, 16'd0, 16'd0} :
                         {bu_reg[2], bu_reg[1], bu_reg[0], tu_reg[2], tu_reg[1], tu_reg[0]};

    ttsb_ram #(.WIDTH(GEOM_W), .DEPTH(MAX_VERTICES)) u_geom_ram (
        .clk   (clk),
        .we    (geom_we),
        .waddr (waddr),
        .wdata (geom_in_reg),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (geom_rdata)
    );

    ttsb_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_VERTICES)) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (waddr),
        .wdata (frame_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (frame_rdata)
    );

    // Common shift of the edge and delta groups
    always_comb
    begin
        logic ok0, ok1;
        ok0 = 1'b1;
        ok1 = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            ok0 = ok0 & fits31(ediff_reg[i]);
            ok1 = ok1 & fits31(ediff_reg[i] >>> 1);
        end
        ke = ok0 ? 2'd0 : (ok1 ? 2'd1 : 2'd2);
        ok0 = 1'b1;
        ok1 = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            ok0 = ok0 & fits31(ddiff_reg[i]);
            ok1 = ok1 & fits31(ddiff_reg[i] >>> 1);
        end
        kd = ok0 ? 2'd0 : (ok1 ? 2'd1 : 2'd2);
    end

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == OP_MUL)
        begin
            case (cmd.cnt)
                5'd0:  begin mul_a = 32'(d_reg[0]); mul_b = 32'(d_reg[3]); end
                5'd1:  begin mul_a = 32'(d_reg[2]); mul_b = 32'(d_reg[1]); end
                5'd2:  begin mul_a = 32'(d_reg[3]); mul_b = 32'(e_reg[0]); end
                5'd3:  begin mul_a = 32'(d_reg[1]); mul_b = 32'(e_reg[3]); end
                5'd4:  begin mul_a = 32'(d_reg[3]); mul_b = 32'(e_reg[1]); end
                5'd5:  begin mul_a = 32'(d_reg[1]); mul_b = 32'(e_reg[4]); end
                5'd6:  begin mul_a = 32'(d_reg[3]); mul_b = 32'(e_reg[2]); end
                5'd7:  begin mul_a = 32'(d_reg[1]); mul_b = 32'(e_reg[5]); end
                5'd8:  begin mul_a = 32'(d_reg[0]); mul_b = 32'(e_reg[3]); end
                5'd9:  begin mul_a = 32'(d_reg[2]); mul_b = 32'(e_reg[0]); end
                5'd10: begin mul_a = 32'(d_reg[0]); mul_b = 32'(e_reg[4]); end
                5'd11: begin mul_a = 32'(d_reg[2]); mul_b = 32'(e_reg[1]); end
                5'd12: begin mul_a = 32'(d_reg[0]); mul_b = 32'(e_reg[5]); end
                5'd13: begin mul_a = 32'(d_reg[2]); mul_b = 32'(e_reg[2]); end
                default: ;
            endcase
        end
        else if ((cmd.op == OP_SQ) && (cmd.cnt < SQ_LAST))
        begin
            mul_a = $signed({2'b00, m_reg[cmd.cnt[1:0]][29:0]});
            mul_b = mul_a;
        end
    end

    assign mul_j   = 4'(cmd.cnt - 5'd1);
    assign lat_idx = 2'(cmd.cnt - 5'd1);
    assign len     = r_reg[31:0];
    assign sq_try  = r_reg + bit_reg;
    assign div_num = {m_reg[cmd.comp][30:0], 14'd0} + 45'(len >> 1);
    assign div_t   = {rem_reg[30:0], dnum_reg[14]};
    assign q_ext   = {1'b0, q_reg};

    // Payload registers, advanced by the controller's command
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg     <= s_tuser;
                geom_in_reg <= s_tdata[GEOM_W-1:0];
                ia_reg      <= s_tdata[GEOM_W +: IDX_W];
                ib_reg      <= s_tdata[GEOM_W + IDX_W +: IDX_W];
                ic_reg      <= s_tdata[GEOM_W + 2 * IDX_W +: IDX_W];
            end
            OP_FETCH:
            begin
                if (cmd.cnt != '0)
                begin
                    vtx_reg[lat_idx] <= geom_rdata;
                end
                if (cmd.cnt == 5'd1)
                begin
                    frame_reg <= frame_rdata;
                end
            end
            OP_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ediff_reg[i]     <= 33'($signed(vtx_reg[1][32*i +: 32])) -
                                        33'($signed(vtx_reg[0][32*i +: 32]));
                    ediff_reg[3 + i] <= 33'($signed(vtx_reg[2][32*i +: 32])) -
                                        33'($signed(vtx_reg[0][32*i +: 32]));
                end
                for (int i = 0; i < 2; i++)
                begin
                    ddiff_reg[i]     <= 33'($signed(vtx_reg[1][96 + 32*i +: 32])) -
                                        33'($signed(vtx_reg[0][96 + 32*i +: 32]));
                    ddiff_reg[2 + i] <= 33'($signed(vtx_reg[2][96 + 32*i +: 32])) -
                                        33'($signed(vtx_reg[0][96 + 32*i +: 32]));
                end
            end
            OP_FIT:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    e_reg[i] <= 31'(ediff_reg[i] >>> ke);
                end
                for (int i = 0; i < 4; i++)
                begin
                    d_reg[i] <= 31'(ddiff_reg[i] >>> kd);
                end
            end
            OP_MUL:
            begin
                // Fold the previous product into its difference of two terms
                if (cmd.cnt != '0)
                begin
                    if (!mul_j[0])
                    begin
                        res_reg[mul_j[3:1]] <= prod_reg;
                    end
                    else
                    begin
                        res_reg[mul_j[3:1]] <= res_reg[mul_j[3:1]] - prod_reg;
                    end
                end
            end
            OP_SIGN:
            begin
                if (res_reg[0] < 0)
                begin
                    for (int i = 1; i < 7; i++)
                    begin
                        res_reg[i] <= -res_reg[i];
                    end
                end
            end
            OP_NLOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [63:0] v;
                    logic [63:0]        a;
                    v = cmd.vsel ? res_reg[4 + i] : res_reg[1 + i];
                    a = v[63] ? 64'(-v) : 64'(v);
                    m_reg[i]   <= a[61:0];
                    neg_reg[i] <= v[63];
                end
            end
            OP_NSHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mx[61:37] != '0)
                    begin
                        m_reg[i] <= m_reg[i] >> 8;
                    end
                    else if (mx[61:30] != '0)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (mx[29:21] == '0)
                    begin
                        m_reg[i] <= m_reg[i] << 8;
                    end
                    else if (!mx[29])
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            OP_SQ:
            begin
                if (cmd.cnt == 5'd1)
                begin
                    n_reg <= prod_reg;
                end
                else if (cmd.cnt != '0)
                begin
                    n_reg <= n_reg + prod_reg;
                end
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            OP_SQRT:
            begin
                if (n_reg >= sq_try)
                begin
                    n_reg <= n_reg - sq_try;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DLOAD:
            begin
                rem_reg  <= 32'(div_num[44:15]);
                dnum_reg <= div_num[14:0];
                q_reg    <= '0;
            end
            OP_DSTEP:
            begin
                if (div_t >= len)
                begin
                    rem_reg <= div_t - len;
                    q_reg   <= {q_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t;
                    q_reg   <= {q_reg[13:0], 1'b0};
                end
                dnum_reg <= {dnum_reg[13:0], 1'b0};
            end
            OP_DSTORE:
            begin
                if (!cmd.vsel)
                begin
                    tu_reg[cmd.comp] <= neg_reg[cmd.comp] ? -q_ext : q_ext;
                end
                else
                begin
                    bu_reg[cmd.comp] <= neg_reg[cmd.comp] ? -q_ext : q_ext;
                end
            end
            OP_RESULT:
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= cmd.stat;
                if (cmd.stat == ST_OK)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            m_tdata_reg[GEOM_W + 2*UNIT_W +: UNIT_W] <= ONE_Q14;
                            m_tdata_reg[GEOM_W + 5*UNIT_W +: UNIT_W] <= ONE_Q14;
                        end
                        CMD_TRI:
                        begin
                            m_tdata_reg[GEOM_W +: FRAME_W] <=
                                {bu_reg[2], bu_reg[1], bu_reg[0],
                                 tu_reg[2], tu_reg[1], tu_reg[0]};
                        end
                        CMD_READ:
                        begin
                            m_tdata_reg <= {frame_reg, vtx_reg[0]};
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Vertex count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_ADD)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.op == OP_RESULT)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: design/triangle_tangent_space_builder.sv
// Top level of the triangle tangent-space builder.
// Depends on ttsb_pkg, ttsb_ctrl, ttsb_dpath (with ttsb_ram) and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: vertex, indices; tuser: command
//  m_*     | out       | m_tvalid/m_tready  | tdata: vertex, tangent, bitangent; tuser: status
//
// One item at a time. make_triangle is dominated by two passes of a 32-step square root
// and six 15-step divisions, which follow the products on one shared multiplier and
// the normalising shifts of each vector.
// Reset is asynchronous and empties the store; stores need no clearing pass.
// A result held in the output register does not stop the next item being accepted;
// that item waits in its last cycle until the register is free.
`default_nettype none
`include "assert_macros.svh"

module triangle_tangent_space_builder
    import ttsb_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pos_x, pos_y, pos_z, tex_s, tex_t, index_a, index_b, index_c, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // vert_x, vert_y, vert_z, vert_s, vert_t, tangent_x/y/z, bitangent_x/y/z
    output logic [M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [1:0]                m_tuser
);

    ctl_cmd_t ctl_cmd;
    dp_sts_t  dp_sts;

    ttsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    ttsb_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctl_cmd),
        .sts      (dp_sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks
    `TTSB_ASSERT_NEXT(a_single_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `TTSB_ASSERT_ALWAYS(a_add_not_full, clk, rst_n, !((ctl_cmd.op == OP_ADD) && dp_sts.full), "vertex appended to full store")
    `TTSB_ASSERT_NEXT(a_result_shown, clk, rst_n, ctl_cmd.op == OP_RESULT, m_tvalid, "result not presented")

endmodule

`default_nettype wire

// File: tb/tb_triangle_tangent_space_builder.sv
// Self-checking testbench for triangle_tangent_space_builder: drives vertex, triangle
// and read commands on the input stream and checks every output transfer against a
// built-in predictor of the vertex store. Depends on ttsb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_triangle_tangent_space_builder;
    import ttsb_pkg::*;

    localparam int NVERT     = 1024;
    localparam int WDOG_MAX  = 5000;
    localparam int TAIL_WAIT = 400;

    typedef struct packed {
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [31:0] vert_z;
        logic [31:0] vert_s;
        logic [31:0] vert_t;
        logic [15:0] tan_x;
        logic [15:0] tan_y;
        logic [15:0] tan_z;
        logic [15:0] btan_x;
        logic [15:0] btan_y;
        logic [15:0] btan_z;
        status_t     status;
    } vertex_reply_t;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = CMD_ADD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // Predictor copy of the vertex store
    int          pos_mem [0:NVERT-1][0:2];
    int          tex_mem [0:NVERT-1][0:1];
    logic [15:0] tan_mem [0:NVERT-1][0:2];
    logic [15:0] btan_mem[0:NVERT-1][0:2];
    int          vert_count;

    vertex_reply_t pending_replies[$];
    int  error_count;
    int  items_sent;
    int  replies_seen;
    int  n_ok, n_degen, n_range, n_full;
    int  idle_cycles = 0;
    bit  idle_en;
    int  stall_left = 0;

    triangle_tangent_space_builder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // Integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Smallest common floor shift bringing the first n values into 31-bit range
    function automatic void fit_range(inout longint v[6], input int n);
        int k;
        bit fits;
        k = 0;
        forever
        begin
            fits = 1'b1;
            for (int i = 0; i < n; i++)
                if ((v[i] >>> k) < -(64'sd1 <<< 30) || (v[i] >>> k) >= (64'sd1 <<< 30))
                    fits = 1'b0;
            if (fits || k >= 3)
                break;
            k++;
        end
        for (int i = 0; i < n; i++)
            v[i] = v[i] >>> k;
    endfunction

    // Normalise a vector to Q2.14; return 0 for a zero-length vector
    function automatic bit unit_vector(input longint v[3], output logic [15:0] u[3]);
        longint unsigned m[3];
        longint unsigned mx, sum, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
            if (m[i] > mx)
                mx = m[i];
            u[i] = '0;
        end
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
            mx <<= 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 14) + len / 2) / len;
            u[i] = v[i] < 0 ? 16'(-q) : 16'(q);
        end
        return 1'b1;
    endfunction

    // Work out the reply to one command and update the predicted store
    function automatic vertex_reply_t tangent_frame_predict(input logic [1:0] cmd,
        input int px, input int py, input int pz, input int ts, input int tt,
        input int ia, input int ib, input int ic);
        vertex_reply_t r;
        longint e[6];
        longint d[6];
        longint det;
        longint tv[3];
        longint bv[3];
        logic [15:0] tu[3];
        logic [15:0] bu[3];
        bit t_ok, b_ok;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ADD:
            begin
                if (vert_count >= NVERT)
                    r.status = ST_FULL;
                else
                begin
                    pos_mem[vert_count] = '{px, py, pz};
                    tex_mem[vert_count] = '{ts, tt};
                    tan_mem[vert_count] = '{16'd0, 16'd0, ONE_Q14};
                    btan_mem[vert_count] = '{16'd0, 16'd0, ONE_Q14};
                    vert_count++;
                    r.tan_z = ONE_Q14;
                    r.btan_z = ONE_Q14;
                end
            end
            CMD_TRI:
            begin
                if (ia >= vert_count || ib >= vert_count || ic >= vert_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e[i] = longint'(pos_mem[ib][i]) - longint'(pos_mem[ia][i]);
                        e[3 + i] = longint'(pos_mem[ic][i]) - longint'(pos_mem[ia][i]);
                    end
                    d[0] = longint'(tex_mem[ib][0]) - longint'(tex_mem[ia][0]);
                    d[1] = longint'(tex_mem[ib][1]) - longint'(tex_mem[ia][1]);
                    d[2] = longint'(tex_mem[ic][0]) - longint'(tex_mem[ia][0]);
                    d[3] = longint'(tex_mem[ic][1]) - longint'(tex_mem[ia][1]);
                    d[4] = 0;
                    d[5] = 0;
                    fit_range(e, 6);
                    fit_range(d, 4);
                    det = d[0] * d[3] - d[2] * d[1];
                    for (int i = 0; i < 3; i++)
                    begin
                        tv[i] = d[3] * e[i] - d[1] * e[3 + i];
                        bv[i] = d[0] * e[3 + i] - d[2] * e[i];
                        if (det < 0)
                        begin
                            tv[i] = -tv[i];
                            bv[i] = -bv[i];
                        end
                    end
                    t_ok = unit_vector(tv, tu);
                    b_ok = unit_vector(bv, bu);
                    if (det == 0 || !t_ok || !b_ok)
                        r.status = ST_DEGEN;
                    else
                    begin
                        tan_mem[ia] = tu;
                        tan_mem[ib] = tu;
                        tan_mem[ic] = tu;
                        btan_mem[ia] = bu;
                        btan_mem[ib] = bu;
                        btan_mem[ic] = bu;
                        {r.tan_x, r.tan_y, r.tan_z} = {tu[0], tu[1], tu[2]};
                        {r.btan_x, r.btan_y, r.btan_z} = {bu[0], bu[1], bu[2]};
                    end
                end
            end
            CMD_READ:
            begin
                if (ia >= vert_count)
                    r.status = ST_RANGE;
                else
                begin
                    r.vert_x = pos_mem[ia][0];
                    r.vert_y = pos_mem[ia][1];
                    r.vert_z = pos_mem[ia][2];
                    r.vert_s = tex_mem[ia][0];
                    r.vert_t = tex_mem[ia][1];
                    {r.tan_x, r.tan_y, r.tan_z} =
                        {tan_mem[ia][0], tan_mem[ia][1], tan_mem[ia][2]};
                    {r.btan_x, r.btan_y, r.btan_z} =
                        {btan_mem[ia][0], btan_mem[ia][1], btan_mem[ia][2]};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one command and hold it until the transfer completes
    task automatic send_item(input logic [1:0] cmd, input int px, input int py,
        input int pz, input int ts, input int tt, input int ia, input int ib, input int ic);
        vertex_reply_t reply;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        reply = tangent_frame_predict(cmd, px, py, pz, ts, tt, ia, ib, ic);
        pending_replies = {pending_replies, reply};
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, ic[9:0], ib[9:0], ia[9:0], tt, ts, pz, py, px};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random(input logic [1:0] cmd, input int ia, input int ib, input int ic);
        send_item(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, ia, ib, ic);
    endtask

    // Add a vertex whose coordinates are either small or full-range
    task automatic add_random_vertex();
        int c[5];
        bit narrow;
        narrow = $urandom_range(0, 3) != 0;
        for (int i = 0; i < 5; i++)
            c[i] = narrow ? $urandom_range(0, 1 << 22) - (1 << 21) : $urandom;
        send_item(CMD_ADD, c[0], c[1], c[2], c[3], c[4],
                  $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    function automatic int pick_index();
        if (vert_count == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(0, vert_count - 1);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Empty store, extremes, both degenerate cases, sign flip and out-of-range indices
    task automatic test_directed();
        send_random(CMD_READ, 0, 0, 0);
        send_random(CMD_TRI, 0, 0, 0);
        send_random(CMD_UNUSED, 5, 6, 7);
        send_item(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(CMD_ADD, 1 << 16, 0, 0, 1 << 16, 0, 1023, 1023, 1023);
        send_item(CMD_ADD, 0, 1 << 16, 0, 0, 1 << 16, 0, 0, 0);
        send_random(CMD_TRI, 0, 1, 2);
        send_random(CMD_READ, 1, 0, 0);
        send_item(CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 0, 0, 0);
        send_item(CMD_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 0, 0, 0);
        send_item(CMD_ADD, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        send_random(CMD_TRI, 3, 4, 5);
        // zero determinant: two equal corners
        send_random(CMD_TRI, 0, 1, 1);
        // zero-length vectors: coincident positions, valid UVs
        send_item(CMD_ADD, 0, 0, 0, 1 << 16, 0, 0, 0, 0);
        send_item(CMD_ADD, 0, 0, 0, 0, 1 << 16, 0, 0, 0);
        send_random(CMD_TRI, 0, 6, 7);
        // negative determinant
        send_random(CMD_TRI, 0, 2, 1);
        send_random(CMD_TRI, 1023, 0, 1);
        send_random(CMD_TRI, 0, 1023, 1);
        send_random(CMD_TRI, 0, 1, 1023);
        send_random(CMD_READ, 1023, 0, 0);
        send_random(CMD_READ, 3, 0, 0);
        send_random(CMD_READ, 7, 0, 0);
    endtask

    // Mixed random traffic, with a full drain now and then
    task automatic test_random_mix(input int count);
        int sel;
        for (int n = 0; n < count; n++)
        begin
            if (n % 250 == 125)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 35 || vert_count < 3)
                add_random_vertex();
            else if (sel < 70)
                send_random(CMD_TRI, pick_index(), pick_index(), pick_index());
            else if (sel < 96)
                send_random(CMD_READ, pick_index(), $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                send_random(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
        end
    endtask

    // Fill the store, then overflow it and use the top entries, with no idling
    task automatic test_store_full();
        idle_en = 1'b0;
        while (vert_count < NVERT)
            add_random_vertex();
        repeat (3) add_random_vertex();
        send_random(CMD_TRI, 1021, 1022, 1023);
        send_random(CMD_TRI, 0, 511, 1023);
        send_random(CMD_READ, 1023, 0, 0);
        send_random(CMD_READ, 1021, 0, 0);
        send_random(CMD_READ, 0, 0, 0);
        s_tvalid <= 1'b0;
    endtask

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        vertex_reply_t want;
        vertex_reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                   m_tdata[159:128], m_tdata[175:160], m_tdata[191:176], m_tdata[207:192],
                   m_tdata[223:208], m_tdata[239:224], m_tdata[255:240], m_tuser};
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("vert_x", want.vert_x, got.vert_x);
                check_field("vert_y", want.vert_y, got.vert_y);
                check_field("vert_z", want.vert_z, got.vert_z);
                check_field("vert_s", want.vert_s, got.vert_s);
                check_field("vert_t", want.vert_t, got.vert_t);
                check_field("tangent_x", want.tan_x, got.tan_x);
                check_field("tangent_y", want.tan_y, got.tan_y);
                check_field("tangent_z", want.tan_z, got.tan_z);
                check_field("bitangent_x", want.btan_x, got.btan_x);
                check_field("bitangent_y", want.btan_y, got.btan_y);
                check_field("bitangent_z", want.btan_z, got.btan_z);
                check_field("status", want.status, got.status);
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_DEGEN: n_degen++;
                    ST_RANGE: n_range++;
                    default:  n_full++;
                endcase
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        items_sent = 0;
        replies_seen = 0;
        n_ok = 0;
        n_degen = 0;
        n_range = 0;
        n_full = 0;
        vert_count = 0;
        idle_en = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(320);
        wait_drained();
        test_store_full();

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d results never arrived", pending_replies.size());
            error_count++;
        end

        $display("Sent %0d commands, checked %0d results (%0d ok, %0d degenerate,",
                 items_sent, replies_seen, n_ok, n_degen);
        $display("  %0d out of range, %0d store full), store filled to capacity.",
                 n_range, n_full);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/ttsb_pkg.sv
design/ttsb_ram.sv
design/ttsb_ctrl.sv
design/ttsb_dpath.sv
design/triangle_tangent_space_builder.sv
tb/tb_triangle_tangent_space_builder.sv
